/* hdl/upr_pkg.sv */
package upr_pkg;

    // Sizing
    localparam int MAX_IN_WIDTH = 1024;
    localparam int MAX_SCALE    = 64;
    localparam int COL_W        = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
    localparam int CNT_W        = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SCALE_REG_W  = 7;
    localparam int WIDTH_REG_W  = 11;
    localparam int RGB_W        = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W      = 3;

    // Item kinds on the input channel
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Result status codes
    localparam logic ST_PIXEL  = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // Register indexes
    localparam logic REG_SCALE    = 1'b0;
    localparam logic REG_IN_WIDTH = 1'b1;

    typedef struct packed {
        logic [SCALE_REG_W-1:0] scale;
        logic [WIDTH_REG_W-1:0] in_width;
    } t_cfg;

    // One queued job for the output side
    typedef struct packed {
        logic             reject;
        logic             use_mem;
        logic [RGB_W-1:0] rgb;
        logic [CNT_W:0]   count;
        logic             term;
        logic [1:0]       pad;
    } t_cmd;

endpackage

/* hdl/upr_in_if.sv */
interface upr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, mode, red, green, blue, input ready);
    modport sink   (input valid, mode, red, green, blue, output ready);
endinterface

/* hdl/upr_out_if.sv */
interface upr_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       last;

    modport source (output valid, status, out_red, out_green, out_blue, pad_bytes, row_end,
                    last, input ready);
    modport sink   (input valid, status, out_red, out_green, out_blue, pad_bytes, row_end,
                    last, output ready);
endinterface

/* hdl/upr_cfg.sv */
module upr_cfg
    import upr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale    <= SCALE_REG_W'(1);
            r_cfg.in_width <= WIDTH_REG_W'(1);
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SCALE:    r_cfg.scale    <= pwdata[SCALE_REG_W-1:0];
                REG_IN_WIDTH: r_cfg.in_width <= pwdata[WIDTH_REG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (paddr[2])
            REG_SCALE:    prdata = 32'(r_cfg.scale);
            REG_IN_WIDTH: prdata = 32'(r_cfg.in_width);
            default:      prdata = '0;
        endcase
    end

endmodule

/* hdl/upr_front.sv */
module upr_front
    import upr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    upr_in_if.sink            i_in,
    input  t_cfg              i_cfg,
    input  logic [QLVL_W-1:0] i_q_level,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [COL_W-1:0]       r_in_column;
    logic [CNT_W-1:0]       r_replays_left;
    logic [COL_W-1:0]       r_replay_column;
    logic [CNT_W-1:0]       r_replay_copy;
    logic [RGB_W-1:0]       r_store [MAX_IN_WIDTH];
    logic [RGB_W-1:0]       r_rd_data;
    logic                   r_s1_valid;
    t_cmd                   r_s1_cmd;

    logic [COL_W-1:0]       n_in_column;
    logic [CNT_W-1:0]       n_replays_left;
    logic [COL_W-1:0]       n_replay_column;
    logic [CNT_W-1:0]       n_replay_copy;
    logic                   n_s1_valid;
    t_cmd                   n_s1_cmd;

    logic                   w_accept;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [RGB_W-1:0]       w_rgb;
    logic [SCALE_REG_W-1:0] w_scale;
    logic [WIDTH_REG_W-1:0] w_width;
    logic [1:0]             w_prod;
    logic [1:0]             w_bytes;
    logic [1:0]             w_pad;
    logic                   w_row_end;
    logic                   w_copy_end;
    logic                   w_col_end;

    // Clamped register values
    always_comb begin
        if (i_cfg.scale == '0) begin
            w_scale = SCALE_REG_W'(1);
        end else if (32'(i_cfg.scale) > MAX_SCALE) begin
            w_scale = SCALE_REG_W'(MAX_SCALE);
        end else begin
            w_scale = i_cfg.scale;
        end
        if (i_cfg.in_width == '0) begin
            w_width = WIDTH_REG_W'(1);
        end else if (32'(i_cfg.in_width) > MAX_IN_WIDTH) begin
            w_width = WIDTH_REG_W'(MAX_IN_WIDTH);
        end else begin
            w_width = i_cfg.in_width;
        end
    end

    // Row padding: only the low two bits of width*scale*3 matter
    assign w_prod  = 2'(w_width[1:0] * w_scale[1:0]);
    assign w_bytes = 2'(w_prod + {w_prod[0], 1'b0});
    assign w_pad   = 2'd0 - w_bytes;

    // Room for the item in flight plus this one
    assign i_in.ready = (32'(i_q_level) + 32'(r_s1_valid)) < QUEUE_DEPTH;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_rgb      = {i_in.red, i_in.green, i_in.blue};

    assign w_row_end  = (32'(r_in_column) + 1) >= 32'(w_width);
    assign w_copy_end = (32'(r_replay_copy) + 1) >= 32'(w_scale);
    assign w_col_end  = (32'(r_replay_column) + 1) >= 32'(w_width);

    // Classify the beat and advance the row counters
    always_comb begin
        n_in_column     = r_in_column;
        n_replays_left  = r_replays_left;
        n_replay_column = r_replay_column;
        n_replay_copy   = r_replay_copy;
        n_s1_valid      = 1'b0;
        n_s1_cmd        = '0;
        w_wr_en         = 1'b0;
        w_rd_en         = 1'b0;
        if (w_accept) begin
            if (i_in.mode == MODE_PIXEL) begin
                n_s1_valid = 1'b1;
                if (r_replays_left != '0) begin
                    n_s1_cmd.reject = 1'b1;
                    n_s1_cmd.count  = (CNT_W+1)'(1);
                end else begin
                    w_wr_en        = 1'b1;
                    n_s1_cmd.rgb   = w_rgb;
                    n_s1_cmd.count = (CNT_W+1)'(w_scale);
                    n_s1_cmd.term  = w_row_end;
                    n_s1_cmd.pad   = w_row_end ? w_pad : 2'd0;
                    if (w_row_end) begin
                        n_in_column     = '0;
                        n_replays_left  = CNT_W'(w_scale - SCALE_REG_W'(1));
                        n_replay_column = '0;
                        n_replay_copy   = '0;
                    end else begin
                        n_in_column = r_in_column + COL_W'(1);
                    end
                end
            end else if (r_replays_left != '0) begin
                // Tick: fetch the stored pixel and step through the replay
                n_s1_valid       = 1'b1;
                w_rd_en          = 1'b1;
                n_s1_cmd.use_mem = 1'b1;
                n_s1_cmd.count   = (CNT_W+1)'(1);
                n_s1_cmd.term    = w_copy_end && w_col_end;
                n_s1_cmd.pad     = (w_copy_end && w_col_end) ? w_pad : 2'd0;
                if (w_copy_end) begin
                    n_replay_copy = '0;
                    if (w_col_end) begin
                        n_replay_column = '0;
                        n_replays_left  = r_replays_left - CNT_W'(1);
                    end else begin
                        n_replay_column = r_replay_column + COL_W'(1);
                    end
                end else begin
                    n_replay_copy = r_replay_copy + CNT_W'(1);
                end
            end
        end
    end

    // Line store, one port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[r_in_column] <= w_rgb;
        end else if (w_rd_en) begin
            r_rd_data <= r_store[r_replay_column];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_column     <= '0;
            r_replays_left  <= '0;
            r_replay_column <= '0;
            r_replay_copy   <= '0;
            r_s1_valid      <= 1'b0;
        end else begin
            r_in_column     <= n_in_column;
            r_replays_left  <= n_replays_left;
            r_replay_column <= n_replay_column;
            r_replay_copy   <= n_replay_copy;
            r_s1_valid      <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= n_s1_cmd;
    end

    // Hand the job on; replayed colour comes from the store read
    always_comb begin
        o_cmd = r_s1_cmd;
        if (r_s1_cmd.use_mem) begin
            o_cmd.rgb = r_rd_data;
        end
    end
    assign o_push = r_s1_valid;

`ifndef SYNTHESIS
    a_reject_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode == MODE_PIXEL && r_replays_left != '0)
        |=> (r_s1_valid && r_s1_cmd.reject && $stable(r_in_column)))
        else $error("rejected pixel did not queue a reject job");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (32'(i_q_level) + 32'(r_s1_valid) < QUEUE_DEPTH))
        else $error("beat accepted without queue room");
    a_tick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode == MODE_TICK && r_replays_left == '0) |=> !r_s1_valid)
        else $error("idle tick produced a job");
`endif

endmodule

/* hdl/upr_queue.sv */
module upr_queue
    import upr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cmd              i_cmd,
    input  logic              i_pop,
    output logic              o_valid,
    output t_cmd              o_cmd,
    output logic [QLVL_W-1:0] o_level
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    assign o_valid = (r_level != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_level = r_level;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + QLVL_W'(1);
                2'b01:   r_level <= r_level - QLVL_W'(1);
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_level) < QUEUE_DEPTH || i_pop))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_level) <= QUEUE_DEPTH)
        else $error("queue level beyond depth");
`endif

endmodule

/* hdl/upr_back.sv */
module upr_back
    import upr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    upr_out_if.source o_out
);

    logic             r_out_valid;
    logic             r_status;
    logic [RGB_W-1:0] r_rgb;
    logic [1:0]       r_pad;
    logic             r_row_end;
    logic             r_last;
    logic [CNT_W-1:0] r_copy;

    logic             w_load;
    logic             w_fin;

    // Emit one copy per cycle into the output register while it is empty or being taken
    assign w_load = i_valid && (!r_out_valid || o_out.ready);
    assign w_fin  = ((CNT_W+1)'(r_copy) + (CNT_W+1)'(1)) >= i_cmd.count;
    assign o_pop  = w_load && w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_copy      <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_copy      <= w_fin ? '0 : r_copy + CNT_W'(1);
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= i_cmd.reject ? ST_REJECT : ST_PIXEL;
            r_rgb     <= i_cmd.rgb;
            r_pad     <= (w_fin && i_cmd.term) ? i_cmd.pad : 2'd0;
            r_row_end <= w_fin && i_cmd.term;
            r_last    <= w_fin;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.out_red   = r_rgb[23:16];
    assign o_out.out_green = r_rgb[15:8];
    assign o_out.out_blue  = r_rgb[7:0];
    assign o_out.pad_bytes = r_pad;
    assign o_out.row_end   = r_row_end;
    assign o_out.last      = r_last;

`ifndef SYNTHESIS
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_REJECT) |-> (r_last && !r_row_end && r_pad == 2'd0))
        else $error("reject beat malformed");
    a_pad_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pad != 2'd0) |-> (r_row_end && r_last))
        else $error("padding away from row end");
    a_copy_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_copy == '0))
        else $error("copy counter not cleared after job");
`endif

endmodule

/* hdl/pixel_replication_upscaler.sv */
// Integer pixel-replication upscaler for 24-bit RGB rows.
// Input channel i_in carries beats of mode/red/green/blue. A pixel beat
// (mode 0) is stored in the line store and produces scale output beats,
// the last one flagged, the final pixel of a row also carrying row_end and
// the row's zero-byte padding. After a row ends, scale-1 replays are owed;
// each tick beat (mode 1) then yields one copy of a stored pixel. A pixel sent while
// replays are owed gives a single beat with status 1. A tick with nothing
// owed is absorbed silently.
// Registers (APB, byte address 4*i): 0 scale, 1 in_width.
// Throughput: one output beat per cycle while o_out.ready allows, so a pixel
// beat occupies the output for scale beats and a tick or reject beat for one;
// a four-entry job queue between classifier and emitter lets input run ahead.
// Reset (synchronous, active low) clears counters, queue and output
// register; scale and in_width return to 1; the line store is not cleared.
// When o_out.ready is low the output beat holds, the queue fills and i_in.ready
// drops once the queue level plus the job in flight reaches the queue depth.
module pixel_replication_upscaler
    import upr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    upr_in_if.sink             i_in,
    upr_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg              w_cfg;
    logic              w_push;
    t_cmd              w_push_cmd;
    logic              w_pop;
    logic              w_q_valid;
    t_cmd              w_q_cmd;
    logic [QLVL_W-1:0] w_q_level;

    upr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    upr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (w_cfg),
        .i_q_level (w_q_level),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    upr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .o_level (w_q_level)
    );

    upr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

/* dv/tb_pixel_replication_upscaler.sv */
module tb_pixel_replication_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    import upr_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_item;

    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] pad_bytes;
        logic       row_end;
        logic       last;
    } t_out_beat;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    upr_in_if  in_bus();
    upr_out_if out_bus();

    pixel_replication_upscaler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and scoreboard storage
    t_pixel_item pending_items[$];
    t_out_beat   expected_beats[$];
    t_pixel_item drive_item;
    t_out_beat   seen_beat;
    t_out_beat   want_beat;

    int   in_sent        = 0;
    int   in_taken       = 0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    int   tx_gap_pct     = 0;
    int   rx_stall_pct   = 0;
    int   phase_num      = -1;
    logic rx_hold;

    // Upscaler shadow: registers, line store and counters
    logic [SCALE_REG_W-1:0] scale_reg;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [RGB_W-1:0]       line_mem [MAX_IN_WIDTH];
    int                     store_fill;
    logic [COL_W-1:0]       in_col;
    logic [CNT_W-1:0]       replays_owed;
    logic [COL_W-1:0]       replay_col;
    logic [CNT_W-1:0]       replay_copy;

    function automatic int scale_now();
        if (scale_reg == 0) return 1;
        if (scale_reg > MAX_SCALE) return MAX_SCALE;
        return int'(scale_reg);
    endfunction

    function automatic int width_now();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_IN_WIDTH) return MAX_IN_WIDTH;
        return int'(width_reg);
    endfunction

    // Zero bytes to round an output row of 3-byte pixels up to a multiple of 4 bytes
    function automatic logic [1:0] pad_now();
        int row_bytes;
        row_bytes = width_now() * scale_now() * 3;
        return 2'((4 - (row_bytes & 3)) & 3);
    endfunction

    // Tick beats still needed to finish the queued row replays
    function automatic int ticks_owed();
        int s;
        int w;
        int n;
        s = scale_now();
        w = width_now();
        if (replays_owed == 0) return 0;
        n = int'(replays_owed) * w * s - int'(replay_col) * s - int'(replay_copy);
        return (n < 1) ? 1 : n;
    endfunction

    // Work out the output beats one accepted input beat causes
    task automatic predict_beats(input t_pixel_item it);
        int               s;
        int               w;
        int               k;
        int               nxt;
        logic [RGB_W-1:0] rgb;
        logic             row_done;
        t_out_beat        b;
        s = scale_now();
        w = width_now();
        if (it.mode == MODE_PIXEL) begin
            if (replays_owed != 0) begin
                b        = '0;
                b.status = ST_REJECT;
                b.last   = 1'b1;
                expected_beats.push_back(b);
            end else begin
                rgb             = {it.red, it.green, it.blue};
                line_mem[in_col] = rgb;
                if (int'(in_col) + 1 > store_fill) store_fill = int'(in_col) + 1;
                row_done = (int'(in_col) + 1 >= w);
                for (k = 0; k < s; k++) begin
                    b = {ST_PIXEL, rgb, (k == s - 1 && row_done) ? pad_now() : 2'b00,
                         k == s - 1 && row_done, k == s - 1};
                    expected_beats.push_back(b);
                end
                if (row_done) begin
                    in_col       = '0;
                    replays_owed = CNT_W'(s - 1);
                    replay_col   = '0;
                    replay_copy  = '0;
                end else begin
                    in_col = in_col + COL_W'(1);
                end
            end
        end else if (replays_owed != 0) begin
            // a copy or column counter beyond a lowered bound ends its pixel or row
            rgb      = line_mem[replay_col];
            row_done = 1'b0;
            nxt      = int'(replay_copy) + 1;
            if (nxt >= s) begin
                replay_copy = '0;
                nxt         = int'(replay_col) + 1;
                if (nxt >= w) begin
                    replay_col   = '0;
                    replays_owed = replays_owed - CNT_W'(1);
                    row_done     = 1'b1;
                end else begin
                    replay_col = COL_W'(nxt);
                end
            end else begin
                replay_copy = CNT_W'(nxt);
            end
            b = {ST_PIXEL, rgb, row_done ? pad_now() : 2'b00, row_done, 1'b1};
            expected_beats.push_back(b);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Input driver: holds a beat until taken, otherwise offers the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (in_taken == in_sent) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
                drive_item = pending_items.pop_front();
                in_bus.mode  <= drive_item.mode;
                in_bus.red   <= drive_item.red;
                in_bus.green <= drive_item.green;
                in_bus.blue  <= drive_item.blue;
                in_bus.valid <= 1'b1;
                in_sent++;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Long receiver hold-off early in the first random phase, so the job queue fills
    initial begin
        rx_hold = 1'b0;
        while (!(phase_num == 1 && pending_items.size() != 0)) @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Monitor: register writes, input beats, output check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_SCALE:    scale_reg = pwdata[SCALE_REG_W-1:0];
                    REG_IN_WIDTH: width_reg = pwdata[WIDTH_REG_W-1:0];
                    default: ;
                endcase
                quiet_cycles = 0;
            end
            if (in_bus.valid && in_bus.ready) begin
                predict_beats({in_bus.mode, in_bus.red, in_bus.green, in_bus.blue});
                in_taken++;
                quiet_cycles = 0;
            end
            if (out_bus.valid && out_bus.ready) begin
                seen_beat = {out_bus.status, out_bus.out_red, out_bus.out_green,
                             out_bus.out_blue, out_bus.pad_bytes, out_bus.row_end,
                             out_bus.last};
                if (expected_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected beat: st=%0d rgb=%06h pad=%0d end=%0d last=%0d",
                                 seen_beat.status, {seen_beat.red, seen_beat.green,
                                 seen_beat.blue}, seen_beat.pad_bytes, seen_beat.row_end,
                                 seen_beat.last);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (seen_beat !== want_beat) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"beat mismatch: want st=%0d rgb=%06h pad=%0d end=%0d ",
                                      "last=%0d, got st=%0d rgb=%06h pad=%0d end=%0d last=%0d"},
                                     want_beat.status,
                                     {want_beat.red, want_beat.green, want_beat.blue},
                                     want_beat.pad_bytes, want_beat.row_end, want_beat.last,
                                     seen_beat.status,
                                     {seen_beat.red, seen_beat.green, seen_beat.blue},
                                     seen_beat.pad_bytes, seen_beat.row_end, seen_beat.last);
                    end
                end
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(input logic mode, input logic [RGB_W-1:0] rgb);
        pending_items.push_back({mode, rgb});
    endtask

    // Wait until every beat is taken and every result is back, then let the pipe settle
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_taken != in_sent ||
               expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Finish any queued replays with ticks
    task automatic drain_replays();
        int n;
        int k;
        while (replays_owed != 0) begin
            n = ticks_owed();
            for (k = 0; k < n; k++) push_item(MODE_TICK, RGB_W'($urandom));
            wait_idle();
        end
    endtask

    task automatic start_phase(input int num, input int sc, input int wd,
                               input t_idle_mode mode, input bit drain);
        int w_eff;
        wait_idle();
        if (drain) drain_replays();
        // never let a replay reach line store entries that were never written
        w_eff = (wd == 0) ? 1 : ((wd > MAX_IN_WIDTH) ? MAX_IN_WIDTH : wd);
        if (replays_owed != 0 && w_eff > store_fill) wd = store_fill;
        apb_write(REG_SCALE, sc);
        apb_write(REG_IN_WIDTH, wd);
        @(posedge i_clk);
        case (mode)
            IDLE_NONE: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SEND: begin tx_gap_pct = 88; rx_stall_pct = 0;  end
            IDLE_RECV: begin tx_gap_pct = 0;  rx_stall_pct = 88; end
            default:   begin tx_gap_pct = 9;  rx_stall_pct = 9;  end
        endcase
        phase_num = num;
    endtask

    // Mostly whole rows followed by their replays, with stray pixels and idle ticks
    task automatic queue_random(input int n);
        int s;
        int w;
        int g_col;
        int g_owed;
        int done;
        s      = scale_now();
        w      = width_now();
        g_col  = int'(in_col);
        g_owed = ticks_owed();
        done   = 0;
        while (done < n) begin
            if (g_owed > 0) begin
                if ($urandom_range(99) < 93) begin
                    push_item(MODE_TICK, RGB_W'($urandom));
                    g_owed--;
                end else begin
                    push_item(MODE_PIXEL, RGB_W'($urandom));
                end
                done++;
            end else if ($urandom_range(99) < 90) begin
                push_item(MODE_PIXEL, RGB_W'($urandom));
                done++;
                g_col++;
                if (g_col >= w) begin
                    g_col  = 0;
                    g_owed = (s - 1) * w * s;
                end
            end else begin
                push_item(MODE_TICK, RGB_W'($urandom));
            end
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_bus.valid  = 1'b0;
        in_bus.mode   = MODE_PIXEL;
        in_bus.red    = '0;
        in_bus.green  = '0;
        in_bus.blue   = '0;
        out_bus.ready = 1'b0;
        scale_reg     = SCALE_REG_W'(1);
        width_reg     = WIDTH_REG_W'(1);
        store_fill    = 0;
        in_col        = '0;
        replays_owed  = '0;
        replay_col    = '0;
        replay_copy   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: scale 2 over 3-pixel rows
        start_phase(0, 2, 3, IDLE_NONE, 1'b0);
        // tick with nothing queued is absorbed
        push_item(MODE_TICK, RGB_W'($urandom));
        // colour extremes, the third pixel ends the row
        push_item(MODE_PIXEL, 24'h000000);
        push_item(MODE_PIXEL, 24'hFFFFFF);
        push_item(MODE_PIXEL, 24'hA55A3C);
        // pixel while the replay is owed gets rejected
        push_item(MODE_PIXEL, 24'h123456);
        repeat (6) push_item(MODE_TICK, RGB_W'($urandom));
        push_item(MODE_TICK, 24'hFFFFFF);
        // leave a row half done across the next register change
        push_item(MODE_PIXEL, 24'hFF0080);
        push_item(MODE_PIXEL, 24'h01FE7F);

        start_phase(1, 4, 5, IDLE_NONE, 1'b0);
        queue_random(60);
        // out-of-range scale and width: 1 and 1024 in effect
        start_phase(2, 0, 2047, IDLE_SEND, 1'b1);
        queue_random(30);
        // width shrinks below the column reached, so the next pixel ends the row
        start_phase(3, 3, 7, IDLE_RECV, 1'b1);
        queue_random(60);
        start_phase(4, 127, 1, IDLE_BOTH, 1'b1);
        queue_random(50);
        // scale drops while a replay may be in progress
        start_phase(5, 2, 1, IDLE_NONE, 1'b0);
        queue_random(40);
        start_phase(6, 1, 1024, IDLE_SEND, 1'b1);
        queue_random(30);
        start_phase(7, 64, 0, IDLE_RECV, 1'b1);
        queue_random(30);
        start_phase(8, 2, 2, IDLE_BOTH, 1'b0);
        queue_random(30);

        wait_idle();
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/upr_pkg.sv
hdl/upr_in_if.sv
hdl/upr_out_if.sv
hdl/upr_cfg.sv
hdl/upr_front.sv
hdl/upr_queue.sv
hdl/upr_back.sv
hdl/pixel_replication_upscaler.sv
dv/tb_pixel_replication_upscaler.sv
